// ===== rtl/pfa_pkg.sv =====
// Shared types and codes of the partition fit allocator.
// Item payload structs, request and fit mode codes, register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

	localparam int unsigned INDEX_BITS = 4;
	localparam int unsigned FIELD_BITS = 16;
	localparam int unsigned CFG_DATA_BITS = 5;
	localparam int unsigned CFG_ADDR_BITS = 1;

	// request types
	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// placement rules; the unused code behaves as first fit
	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_BEST  = 2'd1;
	localparam logic [1:0] MODE_WORST = 2'd2;

	// configuration register indexes
	localparam logic [CFG_ADDR_BITS-1:0] REG_FIT_MODE    = 1'b0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_BLOCK_COUNT = 1'b1;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [INDEX_BITS-1:0] block_index;
		logic [FIELD_BITS-1:0] size;
	} in_item_t;

	typedef struct packed {
		logic                  granted;
		logic [INDEX_BITS-1:0] chosen_index;
		logic [FIELD_BITS-1:0] chosen_size;
		logic [FIELD_BITS-1:0] wastage;
	} out_item_t;

	// control from the sequencer to the scan unit
	typedef struct packed {
		logic       start;
		logic [1:0] mode;
	} scan_ctl_t;

	// status from the scan unit back to the sequencer
	typedef struct packed {
		logic done;
		logic found;
	} scan_sts_t;

endpackage

`default_nettype wire

// ===== rtl/pfa_size_mem.sv =====
// Partition size memory: one write port, one read port, registered read data.
// Stand-alone; no package use.
`timescale 1ns / 1ps
`default_nettype none

module pfa_size_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 16,
	parameter int unsigned AW    = 4
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pfa_scan.sv =====
// Scan unit: walks the size memory one entry a cycle with a single comparator
// and keeps the current pick. Depends on pfa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfa_scan #(
	parameter int unsigned MAX_BLOCKS = 16,
	parameter int unsigned SIZE_WIDTH = 16,
	localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pfa_pkg::scan_ctl_t    ctl,
	input  wire logic [CNT_W-1:0]      count,
	input  wire logic [SIZE_WIDTH-1:0] req,
	input  wire logic [MAX_BLOCKS-1:0] marks,
	output logic                       rd_en,
	output logic      [IDX_W-1:0]      rd_addr,
	input  wire logic [SIZE_WIDTH-1:0] rd_data,
	output pfa_pkg::scan_sts_t         sts,
	output logic      [IDX_W-1:0]      pick_idx,
	output logic      [SIZE_WIDTH-1:0] pick_size,
	output logic      [SIZE_WIDTH-1:0] best
);

	logic                  busy_q;
	logic [CNT_W-1:0]      rd_idx_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SIZE_WIDTH-1:0] req_q;
	logic [1:0]            mode_q;
	logic                  cmp_vld_s1;
	logic [IDX_W-1:0]      cmp_idx_s1;
	logic                  found_q;
	logic [IDX_W-1:0]      pick_q;
	logic [SIZE_WIDTH-1:0] pick_size_q;
	logic [SIZE_WIDTH-1:0] best_q;

	logic                  more;
	logic                  done;
	logic                  elig;
	logic [SIZE_WIDTH-1:0] waste;
	logic                  take;

	assign more    = rd_idx_q < cnt_q;
	assign rd_en   = busy_q && more;
	assign rd_addr = rd_idx_q[IDX_W-1:0];
	assign done    = busy_q && !more && !cmp_vld_s1;

	always_comb begin
		elig  = !marks[cmp_idx_s1] && (rd_data >= req_q);
		waste = rd_data - req_q;
		take  = cmp_vld_s1 && elig &&
			(!found_q ||
			 (mode_q == pfa_pkg::MODE_BEST && waste < best_q) ||
			 (mode_q == pfa_pkg::MODE_WORST && waste > best_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else if (ctl.start) begin
			busy_q     <= 1'b1;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			cmp_vld_s1 <= rd_en;
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (done) begin
				busy_q <= 1'b0;
			end
			if (take) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cnt_q  <= count;
			req_q  <= req;
			mode_q <= ctl.mode;
		end
		if (rd_en) begin
			cmp_idx_s1 <= rd_addr;
		end
		if (take) begin
			pick_q      <= cmp_idx_s1;
			pick_size_q <= rd_data;
			best_q      <= waste;
		end
	end

	assign sts.done   = done;
	assign sts.found  = found_q;
	assign pick_idx   = pick_q;
	assign pick_size  = pick_size_q;
	assign best       = best_q;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> busy_q)
		else $error("scan did not start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ctl.start |=> !busy_q)
		else $error("scan still busy after done");

	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> busy_q)
		else $error("compare outside of a scan");

	a_pick_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && !$past(ctl.start) |-> pick_size_q - req_q == best_q)
		else $error("pick size and wastage disagree");

endmodule

`default_nettype wire

// ===== rtl/partition_fit_allocator.sv =====
// Fixed partition allocator with first, best and worst fit placement.
// Channels: in (in_valid/in_ready/in_data) carries load, allocate and clear
// items; out (out_valid/out_ready/out_data) returns one result per allocate.
// Configuration: cfg_we/cfg_addr/cfg_wdata writes fit_mode (index 0) and
// block_count (index 1) in the cycle that cfg_we is high; write only when idle.
// Load and clear items are done on acceptance and leave the sequencer idle. An
// allocate item scans the first n entries of the partition size memory one entry
// a cycle through a single comparator, n being min(block_count, MAX_BLOCKS);
// the memory read port sets that pace. No item is taken during the scan.
// The result is registered as valid when the sequencer leaves its done state.
// The result sits in an output register; a new item is taken while it waits.
// When the receiver stalls and an allocate finishes with the register still
// full, the sequencer holds the result and takes no item until it drains.
// Reset clears all taken marks, both registers and the channel state;
// partition sizes stay undefined until loaded. Depends on pfa_pkg, pfa_scan, pfa_size_mem.
`timescale 1ns / 1ps
`default_nettype none

module partition_fit_allocator #(
	parameter int unsigned MAX_BLOCKS = 16,
	parameter int unsigned SIZE_WIDTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire pfa_pkg::in_item_t                      in_data,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output pfa_pkg::out_item_t                          out_data,
	input  wire logic                                   cfg_we,
	input  wire logic [pfa_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
	input  wire logic [pfa_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

	localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t                  st_q;
	logic [1:0]              fit_mode_q;
	logic [4:0]              block_count_q;
	logic [MAX_BLOCKS-1:0]   marks_q;
	logic                    out_valid_q;
	pfa_pkg::out_item_t      out_data_q;

	logic                    accept;
	logic                    fire;
	logic                    load_we;
	logic [CNT_W-1:0]        live_cnt;
	pfa_pkg::scan_ctl_t      scan_ctl;
	pfa_pkg::scan_sts_t      scan_sts;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_addr;
	logic [SIZE_WIDTH-1:0]   rd_data;
	logic [IDX_W-1:0]        pick_idx;
	logic [SIZE_WIDTH-1:0]   pick_size;
	logic [SIZE_WIDTH-1:0]   best;

	assign in_ready  = (st_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign fire      = (st_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign load_we = accept && (in_data.req_type == pfa_pkg::REQ_LOAD) &&
		(32'(in_data.block_index) < MAX_BLOCKS);

	always_comb begin
		if (32'(block_count_q) > MAX_BLOCKS) begin
			live_cnt = CNT_W'(MAX_BLOCKS);
		end else begin
			live_cnt = CNT_W'(block_count_q);
		end
		scan_ctl.start = accept && (in_data.req_type == pfa_pkg::REQ_ALLOC);
		scan_ctl.mode  = fit_mode_q;
	end

	pfa_size_mem #(
		.DEPTH (MAX_BLOCKS),
		.WIDTH (SIZE_WIDTH),
		.AW    (IDX_W)
	) u_size_mem (
		.clk   (clk),
		.we    (load_we),
		.waddr (IDX_W'(in_data.block_index)),
		.wdata (SIZE_WIDTH'(in_data.size)),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	pfa_scan #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_WIDTH (SIZE_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (scan_ctl),
		.count     (live_cnt),
		.req       (SIZE_WIDTH'(in_data.size)),
		.marks     (marks_q),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.sts       (scan_sts),
		.pick_idx  (pick_idx),
		.pick_size (pick_size),
		.best      (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q    <= pfa_pkg::MODE_FIRST;
			block_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				pfa_pkg::REG_FIT_MODE: begin
					fit_mode_q <= cfg_wdata[1:0];
				end
				pfa_pkg::REG_BLOCK_COUNT: begin
					block_count_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			marks_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						case (in_data.req_type)
							pfa_pkg::REQ_ALLOC: begin
								st_q <= ST_SCAN;
							end
							pfa_pkg::REQ_CLEAR: begin
								marks_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_sts.done) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold until the output register frees up
					if (fire) begin
						st_q <= ST_IDLE;
						if (scan_sts.found) begin
							marks_q[pick_idx] <= 1'b1;
						end
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q.granted <= scan_sts.found;
			if (scan_sts.found) begin
				out_data_q.chosen_index <= pfa_pkg::INDEX_BITS'(pick_idx);
				out_data_q.chosen_size  <= pfa_pkg::FIELD_BITS'(pick_size);
				out_data_q.wastage      <= pfa_pkg::FIELD_BITS'(best);
			end else begin
				out_data_q.chosen_index <= '0;
				out_data_q.chosen_size  <= '0;
				out_data_q.wastage      <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sim/tb_partition_fit_allocator.sv =====
// Self-checking bench for partition_fit_allocator: load, allocate and clear items
// with random gaps on both channels, allocate results predicted at acceptance.
// Depends on pfa_pkg and rtl/partition_fit_allocator.sv.
`timescale 1ns / 1ps

module tb_partition_fit_allocator;
	import pfa_pkg::*;

	localparam int unsigned PARTS = 16;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned PHASE_ITEMS = 44;
	localparam int unsigned PHASES = 12;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// first load pass; repeated sizes give ties for best and worst fit
	localparam logic [FIELD_BITS-1:0] SEED_SIZES [PARTS] = '{
		16'd100, 16'd0, 16'hFFFF, 16'd300, 16'd300, 16'd50, 16'd1000, 16'd300,
		16'h8000, 16'h7FFF, 16'd1, 16'd2, 16'h5555, 16'hAAAA, 16'd300, 16'd4096
	};
	localparam logic [1:0] PHASE_MODE [10] = '{
		MODE_FIRST, MODE_BEST, MODE_WORST, MODE_SPARE, MODE_BEST,
		MODE_WORST, MODE_FIRST, MODE_BEST, MODE_WORST, MODE_SPARE
	};
	localparam logic [4:0] PHASE_COUNT [10] = '{
		5'd16, 5'd16, 5'd16, 5'd16, 5'd31, 5'd17, 5'd1, 5'd5, 5'd0, 5'd3
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	// allocator mirror
	logic [FIELD_BITS-1:0] part_size [PARTS];
	logic [PARTS-1:0] taken = '0;
	logic [1:0] fit_mode = MODE_FIRST;
	logic [4:0] block_count = '0;

	in_item_t pending_q [$];
	out_item_t grant_q [$];
	out_item_t want;
	bit failed = 1'b0;
	bit steady = 1'b0;
	int unsigned send_gap = 0;
	int unsigned sink_stall = 0;

	partition_fit_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void apply_item(in_item_t it);
		out_item_t res;
		int unsigned live;
		logic [FIELD_BITS-1:0] spare;
		bit found;
		res = '0;
		found = 1'b0;
		case (it.req_type)
			REQ_LOAD: begin
				part_size[it.block_index] = it.size;
			end
			REQ_CLEAR: begin
				taken = '0;
			end
			REQ_ALLOC: begin
				live = (block_count > PARTS) ? PARTS : block_count;
				for (int unsigned j = 0; j < live; j++) begin
					if (!taken[j] && part_size[j] >= it.size) begin
						spare = part_size[j] - it.size;
						if (!found || (fit_mode == MODE_BEST && spare < res.wastage) ||
								(fit_mode == MODE_WORST && spare > res.wastage)) begin
							res.chosen_index = INDEX_BITS'(j);
							res.chosen_size = part_size[j];
							res.wastage = spare;
						end
						found = 1'b1;
						// first fit, and the spare code, stop at the first candidate
						if (fit_mode != MODE_BEST && fit_mode != MODE_WORST)
							break;
					end
				end
				if (found) begin
					res.granted = 1'b1;
					taken[res.chosen_index] = 1'b1;
				end
				grant_q.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_item(logic [1:0] kind, logic [INDEX_BITS-1:0] idx,
			logic [FIELD_BITS-1:0] sz);
		in_item_t it;
		it.req_type = kind;
		it.block_index = idx;
		it.size = sz;
		pending_q.push_back(it);
	endfunction

	// write both registers while idle, then return on a falling edge
	task automatic configure(logic [1:0] mode, logic [4:0] count);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_FIT_MODE;
		cfg_wdata <= CFG_DATA_BITS'(mode);
		@(posedge clk);
		cfg_addr <= REG_BLOCK_COUNT;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we <= 1'b0;
		fit_mode = mode;
		block_count = count;
		@(negedge clk);
	endtask

	task automatic drain();
		do
			@(negedge clk);
		while (pending_q.size() != 0 || in_valid || grant_q.size() != 0);
		// loads and clears give no result; let the block finish them
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				apply_item(in_data);
			if (!in_valid || in_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= pending_q.pop_front();
					send_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_stall <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (grant_q.size() == 0) begin
					$display("%0t: result with none expected: %p", $time, out_data);
					failed = 1'b1;
				end else begin
					want = grant_q.pop_front();
					if (out_data.granted !== want.granted) begin
						$display("%0t: granted expected %0b actual %0b", $time,
							want.granted, out_data.granted);
						failed = 1'b1;
					end
					if (out_data.chosen_index !== want.chosen_index) begin
						$display("%0t: chosen_index expected %0d actual %0d", $time,
							want.chosen_index, out_data.chosen_index);
						failed = 1'b1;
					end
					if (out_data.chosen_size !== want.chosen_size) begin
						$display("%0t: chosen_size expected %0d actual %0d", $time,
							want.chosen_size, out_data.chosen_size);
						failed = 1'b1;
					end
					if (out_data.wastage !== want.wastage) begin
						$display("%0t: wastage expected %0d actual %0d", $time,
							want.wastage, out_data.wastage);
						failed = 1'b1;
					end
				end
			end
			if (sink_stall != 0) begin
				sink_stall <= sink_stall - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				sink_stall <= pick_gap();
			end
		end
	end

	initial begin
		int unsigned pick;
		int unsigned shape;
		int unsigned trim;
		logic [FIELD_BITS-1:0] sz;
		logic [1:0] mode;
		logic [4:0] count;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// load every partition before the first allocate, so no scan sees an
		// unwritten size
		configure(MODE_FIRST, 5'd16);
		for (int unsigned i = 0; i < PARTS; i++)
			queue_item(REQ_LOAD, INDEX_BITS'(i), SEED_SIZES[i]);
		queue_item(REQ_ALLOC, 4'hF, 16'd0);
		queue_item(REQ_ALLOC, 4'h0, 16'hFFFF);
		queue_item(REQ_ALLOC, 4'h0, 16'hFFFF);	// only candidate is taken now
		queue_item(REQ_SPARE, 4'hF, 16'hFFFF);
		queue_item(REQ_CLEAR, 4'h0, 16'd0);
		queue_item(REQ_ALLOC, 4'h0, 16'd300);
		drain();

		// ties on wastage go to the lowest index
		configure(MODE_BEST, 5'd16);
		queue_item(REQ_CLEAR, 4'h0, 16'd0);
		queue_item(REQ_ALLOC, 4'h0, 16'd300);
		queue_item(REQ_ALLOC, 4'h0, 16'd300);
		drain();
		configure(MODE_WORST, 5'd16);
		queue_item(REQ_CLEAR, 4'h0, 16'd0);
		queue_item(REQ_ALLOC, 4'h0, 16'd1);
		drain();
		configure(MODE_FIRST, 5'd0);
		queue_item(REQ_ALLOC, 4'h0, 16'd0);
		drain();

		for (int unsigned p = 0; p < PHASES; p++) begin
			mode = (p < 10) ? PHASE_MODE[p] : 2'($urandom_range(0, 3));
			count = (p < 10) ? PHASE_COUNT[p] : 5'($urandom_range(0, 31));
			steady = (p % 4 == 2);
			configure(mode, count);
			queue_item(REQ_CLEAR, 4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)));
			for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				shape = $urandom_range(0, 9);
				if (pick < 12) begin
					case (shape % 4)
						0: sz = SEED_SIZES[$urandom_range(0, PARTS - 1)];
						1: sz = 16'($urandom_range(0, 65535));
						2: sz = 16'($urandom_range(0, 15) * 64);
						default: sz = shape[2] ? 16'hFFFF : 16'd0;
					endcase
					queue_item(REQ_LOAD, 4'($urandom_range(0, 15)), sz);
				end else if (pick < 21) begin
					queue_item(REQ_CLEAR, 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 65535)));
				end else if (pick < 24) begin
					queue_item(REQ_SPARE, 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 65535)));
				end else begin
					// aim near stored sizes so that grants, exact fits and ties occur
					if (shape < 4) begin
						sz = part_size[$urandom_range(0, PARTS - 1)];
						trim = $urandom_range(0, 3);
						sz = (sz > trim) ? sz - 16'(trim) : 16'd0;
					end else if (shape < 6) begin
						sz = 16'($urandom_range(0, 65535));
					end else if (shape == 6) begin
						sz = 16'd0;
					end else if (shape == 7) begin
						sz = 16'hFFFF;
					end else begin
						sz = 16'($urandom_range(0, 1200));
					end
					queue_item(REQ_ALLOC, 4'($urandom_range(0, 15)), sz);
				end
			end
			drain();
		end

		if (!failed)
			$display("** partition_fit_allocator: PASSED **");
		else
			$display("** partition_fit_allocator: FAILED **");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout, %0d items pending, %0d results outstanding", $time,
			pending_q.size(), grant_q.size());
		$display("** partition_fit_allocator: FAILED **");
		$finish;
	end

endmodule

// ===== partition_fit_allocator.f =====
rtl/pfa_pkg.sv
rtl/pfa_size_mem.sv
rtl/pfa_scan.sv
rtl/partition_fit_allocator.sv
sim/tb_partition_fit_allocator.sv
